@@ hdl/isort_pkg.sv @@
// isort_pkg: shared constants and types for the insertion sorter
// used by isort_cell and insertion_sorter; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package isort_pkg;

   // number of cells in the chain, which is the run capacity (2..64)
   localparam int unsigned MAX_ITEMS = 64;

   // width of one sorted value
   localparam int unsigned VALUE_W = 32;

   // per-cycle command broadcast to every cell
   typedef struct packed {
      logic insert;  // take a new value into the sorted row
      logic shift;   // move the row down one place toward the output
   } cell_ctl_type;

endpackage : isort_pkg

`default_nettype wire

@@ hdl/isort_cell.sv @@
// isort_cell: one compare-and-shift cell of the sorting chain
// depends on isort_pkg for widths and the control struct
`timescale 1ns / 1ps
`default_nettype none

module isort_cell
   import isort_pkg::*;
(
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire cell_ctl_type              ctl,
   input  wire logic signed [VALUE_W-1:0] new_value,
   // neighbor one place below (toward the output)
   input  wire logic signed [VALUE_W-1:0] lower_value,
   input  wire logic                      lower_valid,
   input  wire logic                      lower_gt,
   // neighbor one place above
   input  wire logic signed [VALUE_W-1:0] upper_value,
   input  wire logic                      upper_valid,
   output logic signed [VALUE_W-1:0]      value,
   output logic                           valid,
   output logic                           gt
);

   logic signed [VALUE_W-1:0] value_ff;
   logic signed [VALUE_W-1:0] value_in;
   logic                      valid_ff;
   logic                      valid_in;

   // an empty cell counts as greater than anything; equal values stay put
   assign gt = !valid_ff || (value_ff > new_value);

   // next cell contents
   always_comb begin
      value_in = value_ff;
      valid_in = valid_ff;
      if (ctl.shift) begin
         value_in = upper_value;
         valid_in = upper_valid;
      end else if (ctl.insert) begin
         if (gt) begin
            value_in = lower_gt ? lower_value : new_value;
         end
         valid_in = valid_ff | lower_valid;
      end
   end

   // occupancy flag
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // stored value
   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value = value_ff;
   assign valid = valid_ff;

endmodule : isort_cell

`default_nettype wire

@@ hdl/insertion_sorter.sv @@
// insertion_sorter: top level, a row of compare-and-shift cells with an output register
// depends on isort_pkg and isort_cell
`timescale 1ns / 1ps
`default_nettype none

// Stable ascending sort of runs of signed 32-bit values, built as a chain of
// MAX_ITEMS cells. Every accepted request is inserted in place: cells holding
// a strictly greater value move up one place, so equal values keep arrival order.
// Requests are taken one per cycle while a run arrives. The request flagged with
// tlast starts the drain: the chain shifts toward the output one place per cycle
// that the output register is free, and req_tready stays low until the final
// result of the run is loaded. Values beyond MAX_ITEMS are dropped and every
// result of that run carries the overflow flag in rsp_tuser.
module insertion_sorter
   import isort_pkg::*;
(
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_tvalid,
   output logic                     req_tready,
   input  wire logic [VALUE_W-1:0]  req_tdata,   // [31:0] value
   input  wire logic                req_tlast,   // is_last
   output logic                     rsp_tvalid,
   input  wire logic                rsp_tready,
   output logic [VALUE_W-1:0]       rsp_tdata,   // [31:0] sorted_value
   output logic                     rsp_tlast,   // last_out
   output logic                     rsp_tuser    // [0] overflowed
);

   logic signed [VALUE_W-1:0] cell_value [MAX_ITEMS];
   logic [MAX_ITEMS-1:0]      valid_vec;
   logic [MAX_ITEMS-1:0]      gt_vec;
   cell_ctl_type              ctl;
   logic                      req_take;
   logic                      full;
   logic                      out_free;

   logic                      drain_ff;
   logic                      drain_in;
   logic                      dropped_ff;
   logic                      dropped_in;
   logic                      rsp_valid_ff;
   logic                      rsp_valid_in;
   logic [VALUE_W-1:0]        rsp_data_ff;
   logic                      rsp_last_ff;
   logic                      rsp_user_ff;

   // request handshake and chain commands
   assign req_tready = !drain_ff;
   assign req_take   = req_tvalid && req_tready;
   assign full       = valid_vec[MAX_ITEMS-1];
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign ctl.insert = req_take && !full;
   assign ctl.shift  = drain_ff && out_free && valid_vec[0];

   // chain of cells
   for (genvar i = 0; i < MAX_ITEMS; i++) begin : g_cell
      logic signed [VALUE_W-1:0] lower_value;
      logic                      lower_valid;
      logic                      lower_gt;
      logic signed [VALUE_W-1:0] upper_value;
      logic                      upper_valid;

      if (i == 0) begin : g_bottom
         assign lower_value = '0;
         assign lower_valid = 1'b1;
         assign lower_gt    = 1'b0;
      end else begin : g_mid_low
         assign lower_value = cell_value[i-1];
         assign lower_valid = valid_vec[i-1];
         assign lower_gt    = gt_vec[i-1];
      end

      if (i == MAX_ITEMS - 1) begin : g_top
         assign upper_value = '0;
         assign upper_valid = 1'b0;
      end else begin : g_mid_high
         assign upper_value = cell_value[i+1];
         assign upper_valid = valid_vec[i+1];
      end

      isort_cell u_cell (
         .clock       (clock),
         .reset       (reset),
         .ctl         (ctl),
         .new_value   ($signed(req_tdata)),
         .lower_value (lower_value),
         .lower_valid (lower_valid),
         .lower_gt    (lower_gt),
         .upper_value (upper_value),
         .upper_valid (upper_valid),
         .value       (cell_value[i]),
         .valid       (valid_vec[i]),
         .gt          (gt_vec[i])
      );
   end

   // drain mode and overflow flag
   always_comb begin
      drain_in   = drain_ff;
      dropped_in = dropped_ff;
      if (req_take && full) begin
         dropped_in = 1'b1;
      end
      if (req_take && req_tlast) begin
         drain_in = 1'b1;
      end
      if (ctl.shift && !valid_vec[1]) begin
         drain_in   = 1'b0;
         dropped_in = 1'b0;
      end
   end

   // output register valid
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctl.shift) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         drain_ff     <= 1'b0;
         dropped_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         drain_ff     <= drain_in;
         dropped_ff   <= dropped_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output payload, loaded from the bottom cell
   always_ff @(posedge clock) begin
      if (ctl.shift) begin
         rsp_data_ff <= cell_value[0];
         rsp_last_ff <= !valid_vec[1];
         rsp_user_ff <= dropped_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tlast  = rsp_last_ff;
   assign rsp_tuser  = rsp_user_ff;

`ifndef SYNTHESIS
   // occupied cells always form an unbroken row from the bottom
   a_valid_contiguous : assert property (@(posedge clock) disable iff (reset)
      ((valid_vec + 1'b1) & valid_vec) == '0)
      else $error("occupied cells are not contiguous");

   // a run that has ended always has something to emit
   a_last_has_data : assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tlast) |=> valid_vec[0])
      else $error("run ended with an empty chain");

   // once the final result is loaded, the chain is empty and drain is over
   a_final_result : assert property (@(posedge clock) disable iff (reset)
      (ctl.shift && !valid_vec[1]) |=> (!drain_ff && !valid_vec[0]))
      else $error("final result while values remain");

   // no new request is taken while a run is draining
   a_no_take_in_drain : assert property (@(posedge clock) disable iff (reset)
      (drain_ff && valid_vec[0]) |-> !ctl.insert)
      else $error("insert during drain");
`endif

endmodule : insertion_sorter

`default_nettype wire

@@ dv/tb_insertion_sorter.sv @@
// tb_insertion_sorter: self-checking testbench for the streaming insertion sorter
// depends on isort_pkg and insertion_sorter; drives runs of values, checks sorted output
`timescale 1ns / 1ps

module tb_insertion_sorter;
   import isort_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 200000;
   localparam int unsigned RANDOM_ITEMS = 110;
   localparam int unsigned DRAIN_CYCLES = 2 * MAX_ITEMS + 16;

   // one sorted result as it leaves the block
   typedef struct packed {
      logic signed [VALUE_W-1:0] sorted_value;
      logic                      last_out;
      logic                      overflowed;
   } sorted_out_type;

   // one row of the directed table; a known result is typed in for one-value runs
   typedef struct packed {
      logic signed [VALUE_W-1:0] value;
      logic                      is_last;
      logic                      known;
      logic signed [VALUE_W-1:0] known_value;
      logic                      known_ovf;
   } sort_row_type;

   localparam int unsigned N_ROWS = 20;
   localparam sort_row_type DIRECTED_ROWS [N_ROWS] = '{
      // one-value runs at the extremes
      '{32'h0000_0000, 1'b1, 1'b1, 32'h0000_0000, 1'b0},
      '{32'h7fff_ffff, 1'b1, 1'b1, 32'h7fff_ffff, 1'b0},
      '{32'h8000_0000, 1'b1, 1'b1, 32'h8000_0000, 1'b0},
      '{32'hffff_ffff, 1'b1, 1'b1, 32'hffff_ffff, 1'b0},
      // mixed run with both extremes and repeated values
      '{32'h0000_0007, 1'b0, 1'b0, 32'h0, 1'b0},
      '{32'hffff_fff9, 1'b0, 1'b0, 32'h0, 1'b0},
      '{32'h0000_0007, 1'b0, 1'b0, 32'h0, 1'b0},
      '{32'h8000_0000, 1'b0, 1'b0, 32'h0, 1'b0},
      '{32'h7fff_ffff, 1'b0, 1'b0, 32'h0, 1'b0},
      '{32'h0000_0000, 1'b0, 1'b0, 32'h0, 1'b0},
      '{32'h0000_0007, 1'b1, 1'b0, 32'h0, 1'b0},
      // all equal
      '{32'h0000_0003, 1'b0, 1'b0, 32'h0, 1'b0},
      '{32'h0000_0003, 1'b0, 1'b0, 32'h0, 1'b0},
      '{32'h0000_0003, 1'b1, 1'b0, 32'h0, 1'b0},
      // descending arrival, every insert lands at the bottom
      '{32'h0000_0004, 1'b0, 1'b0, 32'h0, 1'b0},
      '{32'h0000_0003, 1'b0, 1'b0, 32'h0, 1'b0},
      '{32'h0000_0002, 1'b0, 1'b0, 32'h0, 1'b0},
      '{32'h0000_0001, 1'b1, 1'b0, 32'h0, 1'b0},
      // ascending arrival of negative values
      '{32'hffff_fffe, 1'b0, 1'b0, 32'h0, 1'b0},
      '{32'hffff_ffff, 1'b1, 1'b0, 32'h0, 1'b0}
   };

   logic                clock;
   logic                reset = 1'b1;
   logic                req_tvalid = 1'b0;
   logic                req_tready;
   logic [VALUE_W-1:0]  req_tdata = '0;     // [31:0] value
   logic                req_tlast = 1'b0;   // is_last
   logic                rsp_tvalid;
   logic                rsp_tready = 1'b0;
   logic [VALUE_W-1:0]  rsp_tdata;          // [31:0] sorted_value
   logic                rsp_tlast;          // last_out
   logic                rsp_tuser;          // [0] overflowed

   // sorted copy of the current run and the results still owed
   logic signed [VALUE_W-1:0] run_store [MAX_ITEMS];
   int unsigned               run_count = 0;
   logic                      run_dropped = 1'b0;
   sorted_out_type            owed_results [$];

   int unsigned    errors = 0;
   int unsigned    cycles = 0;
   int unsigned    burst_left = 0;
   logic [7:0]     stall_phase = '0;
   sorted_out_type seen;
   sorted_out_type want;

   insertion_sorter i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   // clock
   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // stable insert into the run copy; on the last value queue the whole run
   task automatic insert_sorted(input logic signed [VALUE_W-1:0] value, input logic is_last,
                                input logic known, input logic signed [VALUE_W-1:0] known_value,
                                input logic known_ovf);
      int pos;
      if (run_count >= MAX_ITEMS) begin
         run_dropped = 1'b1;
      end else begin
         pos = run_count;
         // only strictly greater entries move up, so equal values keep arrival order
         while (pos > 0 && run_store[pos-1] > value) begin
            run_store[pos] = run_store[pos-1];
            pos--;
         end
         run_store[pos] = value;
         run_count++;
      end
      if (is_last) begin
         if (known)
            owed_results.push_back(sorted_out_type'{known_value, 1'b1, known_ovf});
         else
            for (int k = 0; k < run_count; k++)
               owed_results.push_back(sorted_out_type'{run_store[k], k == run_count - 1,
                                                       run_dropped});
         run_count = 0;
         run_dropped = 1'b0;
      end
   endtask

   // send one request, with bursts and random gaps between them
   task automatic send_request(input logic signed [VALUE_W-1:0] value, input logic is_last,
                               input logic known, input logic signed [VALUE_W-1:0] known_value,
                               input logic known_ovf);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                  : $urandom_range(1, 8);
         if (gap > 0) begin
            @(negedge clock);
            req_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_tvalid <= 1'b1;
      req_tdata  <= value;
      req_tlast  <= is_last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      insert_sorted(value, is_last, known, known_value, known_ovf);
   endtask

   // hold off the sender until every owed result has arrived
   task automatic wait_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      burst_left = 0;
      while (owed_results.size() != 0) @(posedge clock);
   endtask

   // random value: small range for repeats, extremes, or any pattern
   function automatic logic signed [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 5))
         0, 1: return VALUE_W'($urandom_range(0, 8)) - VALUE_W'(4);
         2: begin
            case ($urandom_range(0, 3))
               0: return 32'h7fff_ffff;
               1: return 32'h8000_0000;
               2: return 32'h0000_0000;
               default: return 32'hffff_ffff;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   // stimulus
   initial begin
      int unsigned sent;
      int unsigned run_len;
      int unsigned run_idx;
      repeat (11) @(negedge clock);
      reset <= 1'b0;

      // directed table
      for (int r = 0; r < N_ROWS; r++)
         send_request(DIRECTED_ROWS[r].value, DIRECTED_ROWS[r].is_last, DIRECTED_ROWS[r].known,
                      DIRECTED_ROWS[r].known_value, DIRECTED_ROWS[r].known_ovf);
      wait_drained();

      // random runs, one of them overflowing the store including its last value
      sent = 0;
      run_idx = 0;
      while (sent < RANDOM_ITEMS) begin
         if (run_idx == 2)
            run_len = MAX_ITEMS + 2;
         else if ($urandom_range(0, 9) == 0)
            run_len = 1;
         else
            run_len = $urandom_range(2, 8);
         for (int k = 0; k < run_len; k++)
            send_request(pick_value(), k == run_len - 1, 1'b0, '0, 1'b0);
         sent += run_len;
         if (run_idx == 2 || $urandom_range(0, 7) == 0)
            wait_drained();
         run_idx++;
      end

      // wait out the last results, then give the block time to misbehave
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (owed_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (owed_results.size() != 0) begin
         $error("%0d sorted results never arrived", owed_results.size());
         errors++;
      end
      if (errors == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

   // receiver stalls, pattern chosen by the top two bits of stall_phase
   always @(negedge clock) begin
      stall_phase <= stall_phase + 8'd1;
      case (stall_phase[7:6])
         2'd0: rsp_tready <= 1'b1;
         2'd1: rsp_tready <= 1'($urandom_range(0, 1));
         2'd2: rsp_tready <= (stall_phase[1:0] == 2'b11);
         default: rsp_tready <= ($urandom_range(0, 7) != 0);
      endcase
   end

   // compare each result with the oldest one owed
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         seen = sorted_out_type'{rsp_tdata, rsp_tlast, rsp_tuser};
         if (owed_results.size() == 0) begin
            $error("unexpected result: sorted_value %0d", $signed(rsp_tdata));
            errors++;
         end else begin
            want = owed_results.pop_front();
            if (seen.sorted_value !== want.sorted_value) begin
               $error("sorted_value: expected %0d, got %0d", want.sorted_value,
                      seen.sorted_value);
               errors++;
            end
            if (seen.last_out !== want.last_out) begin
               $error("last_out: expected %0b, got %0b", want.last_out, seen.last_out);
               errors++;
            end
            if (seen.overflowed !== want.overflowed) begin
               $error("overflowed: expected %0b, got %0b", want.overflowed, seen.overflowed);
               errors++;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("end of test: mismatches");
         $finish;
      end
   end

endmodule
